// File: src/tcsr_pkg.sv
// shared types and constants for the touchpad click and swipe recognizer
// no dependencies; used by tcsr_swipe_judge and touchpad_click_swipe_recognizer
package tcsr_pkg;

  // coordinate width default
  localparam int unsigned COORD_BITS = 11;

  // configuration register index width and indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_X       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_Y       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_LIMIT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_START = 2'd3;

  // register reset values
  localparam int unsigned RESET_THR_X       = 340;
  localparam int unsigned RESET_THR_Y       = 190;
  localparam int unsigned RESET_LEFT_LIMIT  = 640;
  localparam int unsigned RESET_RIGHT_START = 1280;

  // gesture codes
  typedef enum logic [2:0] {
    G_NONE        = 3'd0,
    G_LEFT_PRESS  = 3'd1,
    G_MID_PRESS   = 3'd2,
    G_RIGHT_PRESS = 3'd3,
    G_SWIPE_LEFT  = 3'd4,
    G_SWIPE_RIGHT = 3'd5,
    G_SWIPE_UP    = 3'd6,
    G_SWIPE_DOWN  = 3'd7
  } gesture_e;

endpackage

// File: src/tcsr_swipe_judge.sv
// swipe classification from a finished touch track
// depends on tcsr_pkg
module tcsr_swipe_judge #(
  parameter int unsigned CW = tcsr_pkg::COORD_BITS
) (
  input  logic [CW-1:0]      start_x_i,
  input  logic [CW-1:0]      start_y_i,
  input  logic [CW-1:0]      latest_x_i,
  input  logic [CW-1:0]      latest_y_i,
  input  logic [CW-1:0]      thr_x_i,
  input  logic [CW-1:0]      thr_y_i,
  output tcsr_pkg::gesture_e gesture_o
);

  logic [CW:0]   dx, dy;
  logic [CW:0]   dx_abs, dy_abs;
  logic [CW-1:0] ax, ay;
  logic          dx_neg, dy_neg;

  // signed displacement, one extra bit for the sign
  assign dx     = {1'b0, latest_x_i} - {1'b0, start_x_i};
  assign dy     = {1'b0, latest_y_i} - {1'b0, start_y_i};
  assign dx_neg = dx[CW];
  assign dy_neg = dy[CW];

  // magnitudes always fit in the coordinate width
  assign dx_abs = dx_neg ? (~dx + 1'b1) : dx;
  assign dy_abs = dy_neg ? (~dy + 1'b1) : dy;
  assign ax     = dx_abs[CW-1:0];
  assign ay     = dy_abs[CW-1:0];

  // thresholds, then the dominant axis; ties go horizontal
  always_comb begin
    if (ax < thr_x_i && ay < thr_y_i) begin
      gesture_o = tcsr_pkg::G_NONE;
    end else if (ax >= ay) begin
      gesture_o = dx_neg ? tcsr_pkg::G_SWIPE_LEFT : tcsr_pkg::G_SWIPE_RIGHT;
    end else begin
      gesture_o = dy_neg ? tcsr_pkg::G_SWIPE_UP : tcsr_pkg::G_SWIPE_DOWN;
    end
  end

endmodule

// File: src/touchpad_click_swipe_recognizer.sv
// touchpad click and swipe recognizer, top level
// an input transfer reaches the result through the input register and then the result register
// one report per cycle while the output is not stalled; the state update and classification are combinational
// while a result waits, the input stage takes a report only if it is empty, and then stalls
// reset (rst_ni, async, low) clears tracking state and loads the default thresholds/regions
// depends on tcsr_pkg and tcsr_swipe_judge
module touchpad_click_swipe_recognizer #(
  parameter int unsigned COORD_BITS = tcsr_pkg::COORD_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [tcsr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_BITS-1:0]          cfg_wdata_i,
  // report input
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           click_pressed_i,
  input  logic                           has_touch_data_i,
  input  logic                           touch_active_i,
  input  logic [COORD_BITS-1:0]          touch_x_i,
  input  logic [COORD_BITS-1:0]          touch_y_i,
  // gesture output
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     gesture_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam logic [CW-1:0] THR_X_RST       = CW'(tcsr_pkg::RESET_THR_X);
  localparam logic [CW-1:0] THR_Y_RST       = CW'(tcsr_pkg::RESET_THR_Y);
  localparam logic [CW-1:0] LEFT_LIMIT_RST  = CW'(tcsr_pkg::RESET_LEFT_LIMIT);
  localparam logic [CW-1:0] RIGHT_START_RST = CW'(tcsr_pkg::RESET_RIGHT_START);

  // configuration registers
  logic [CW-1:0] thr_x_q, thr_y_q, left_limit_q, right_start_q;

  // input register
  logic          in_valid_q;
  logic          click_q, touch_q;
  logic [CW-1:0] x_q, y_q;

  // recognizer state
  logic          was_clicking_q, was_clicking_d;
  logic          tracking_q, tracking_d;
  logic          suppressed_q, suppressed_d;
  logic [CW-1:0] start_x_q, start_x_d, start_y_q, start_y_d;
  logic [CW-1:0] latest_x_q, latest_x_d, latest_y_q, latest_y_d;

  // result register
  logic               out_valid_q;
  tcsr_pkg::gesture_e gesture_q, gesture_d, swipe_g, region_g;

  logic in_xfer, advance, click_edge, still_clicking;

  // handshake: the input stage drains whenever the result register can take a value
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_x_q       <= THR_X_RST;
      thr_y_q       <= THR_Y_RST;
      left_limit_q  <= LEFT_LIMIT_RST;
      right_start_q <= RIGHT_START_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tcsr_pkg::CFG_THR_X:       thr_x_q       <= cfg_wdata_i;
        tcsr_pkg::CFG_THR_Y:       thr_y_q       <= cfg_wdata_i;
        tcsr_pkg::CFG_LEFT_LIMIT:  left_limit_q  <= cfg_wdata_i;
        tcsr_pkg::CFG_RIGHT_START: right_start_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      click_q <= click_pressed_i;
      touch_q <= has_touch_data_i && touch_active_i;
      x_q     <= touch_x_i;
      y_q     <= touch_y_i;
    end
  end

  // region of a click; no touch means middle, left test first
  always_comb begin
    if (!touch_q) begin
      region_g = tcsr_pkg::G_MID_PRESS;
    end else if (x_q < left_limit_q) begin
      region_g = tcsr_pkg::G_LEFT_PRESS;
    end else if (x_q < right_start_q) begin
      region_g = tcsr_pkg::G_MID_PRESS;
    end else begin
      region_g = tcsr_pkg::G_RIGHT_PRESS;
    end
  end

  tcsr_swipe_judge #(
    .CW (CW)
  ) u_judge (
    .start_x_i  (start_x_q),
    .start_y_i  (start_y_q),
    .latest_x_i (latest_x_q),
    .latest_y_i (latest_y_q),
    .thr_x_i    (thr_x_q),
    .thr_y_i    (thr_y_q),
    .gesture_o  (swipe_g)
  );

  assign click_edge     = !was_clicking_q && click_q;
  assign still_clicking = was_clicking_q && click_q;

  // next state and gesture for the report in the input register
  always_comb begin
    was_clicking_d = was_clicking_q;
    tracking_d     = tracking_q;
    suppressed_d   = suppressed_q;
    start_x_d      = start_x_q;
    start_y_d      = start_y_q;
    latest_x_d     = latest_x_q;
    latest_y_d     = latest_y_q;
    gesture_d      = tcsr_pkg::G_NONE;
    if (click_edge) begin
      // press reported, touch tracking left alone
      was_clicking_d = 1'b1;
      gesture_d      = region_g;
      if (tracking_q) begin
        suppressed_d = 1'b1;
      end
    end else begin
      was_clicking_d = still_clicking;
      if (!still_clicking && touch_q && !tracking_q) begin
        // new track
        tracking_d   = 1'b1;
        start_x_d    = x_q;
        start_y_d    = y_q;
        latest_x_d   = x_q;
        latest_y_d   = y_q;
        suppressed_d = 1'b0;
      end else if (tracking_q && touch_q) begin
        latest_x_d = x_q;
        latest_y_d = y_q;
      end else if (tracking_q && !touch_q) begin
        // finger lifted
        tracking_d = 1'b0;
        if (!suppressed_q) begin
          gesture_d = swipe_g;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_clicking_q <= 1'b0;
      tracking_q     <= 1'b0;
      suppressed_q   <= 1'b0;
      start_x_q      <= '0;
      start_y_q      <= '0;
      latest_x_q     <= '0;
      latest_y_q     <= '0;
    end else if (advance) begin
      was_clicking_q <= was_clicking_d;
      tracking_q     <= tracking_d;
      suppressed_q   <= suppressed_d;
      start_x_q      <= start_x_d;
      start_y_q      <= start_y_d;
      latest_x_q     <= latest_x_d;
      latest_y_q     <= latest_y_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      gesture_q <= gesture_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign gesture_o   = gesture_q;

endmodule

// File: dv/tb_touchpad_click_swipe_recognizer.sv
// testbench for touchpad_click_swipe_recognizer: directed and random touchpad reports
// with random idling, gestures checked in order against a local model of the recognizer
// depends on tcsr_pkg and the touchpad_click_swipe_recognizer rtl
`timescale 1ns / 100ps

module tb_touchpad_click_swipe_recognizer;

  localparam int CB          = tcsr_pkg::COORD_BITS;
  localparam int COORD_MAX   = (1 << CB) - 1;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic          click;
    logic          has_touch;
    logic          active;
    logic [CB-1:0] x;
    logic [CB-1:0] y;
  } report_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [tcsr_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [CB-1:0]                  cfg_wdata_i;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic                           click_pressed_i;
  logic                           has_touch_data_i;
  logic                           touch_active_i;
  logic [CB-1:0]                  touch_x_i;
  logic [CB-1:0]                  touch_y_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic [2:0]                     gesture_o;

  touchpad_click_swipe_recognizer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .click_pressed_i  (click_pressed_i),
    .has_touch_data_i (has_touch_data_i),
    .touch_active_i   (touch_active_i),
    .touch_x_i        (touch_x_i),
    .touch_y_i        (touch_y_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .gesture_o        (gesture_o)
  );

  report_t            pending_reports[$];
  tcsr_pkg::gesture_e gestures_due[$];
  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  int                 send_gap = 0;
  int                 hold_left = 0;
  bit                 report_taken = 1'b0;
  bit                 calm = 1'b0;

  // model copy of the registers
  logic [CB-1:0] thr_x       = CB'(tcsr_pkg::RESET_THR_X);
  logic [CB-1:0] thr_y       = CB'(tcsr_pkg::RESET_THR_Y);
  logic [CB-1:0] left_limit  = CB'(tcsr_pkg::RESET_LEFT_LIMIT);
  logic [CB-1:0] right_start = CB'(tcsr_pkg::RESET_RIGHT_START);

  // model copy of the gesture state
  bit            was_clicking = 1'b0;
  bit            tracking = 1'b0;
  bit            suppressed = 1'b0;
  logic [CB-1:0] start_x = '0;
  logic [CB-1:0] start_y = '0;
  logic [CB-1:0] latest_x = '0;
  logic [CB-1:0] latest_y = '0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // advance the gesture state by one report and return the gesture it yields
  function automatic tcsr_pkg::gesture_e next_gesture(report_t r);
    bit                 touching;
    int                 dx, dy, ax, ay;
    tcsr_pkg::gesture_e g;
    touching = r.has_touch && r.active;
    g = tcsr_pkg::G_NONE;
    // press edge: region from x, tracking left alone this step
    if (!was_clicking && r.click) begin
      if (!touching) g = tcsr_pkg::G_MID_PRESS;
      else if (r.x < left_limit) g = tcsr_pkg::G_LEFT_PRESS;
      else if (r.x < right_start) g = tcsr_pkg::G_MID_PRESS;
      else g = tcsr_pkg::G_RIGHT_PRESS;
      was_clicking = 1'b1;
      if (tracking) suppressed = 1'b1;
      return g;
    end
    if (was_clicking && !r.click) was_clicking = 1'b0;
    // touch tracking
    if (!was_clicking && touching && !tracking) begin
      tracking = 1'b1;
      start_x = r.x;
      start_y = r.y;
      latest_x = r.x;
      latest_y = r.y;
      suppressed = 1'b0;
    end else if (tracking && touching) begin
      latest_x = r.x;
      latest_y = r.y;
    end else if (tracking && !touching) begin
      tracking = 1'b0;
      if (!suppressed) begin
        dx = int'(latest_x) - int'(start_x);
        dy = int'(latest_y) - int'(start_y);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        // horizontal wins a tie, zero motion counts as positive
        if (ax < int'(thr_x) && ay < int'(thr_y)) g = tcsr_pkg::G_NONE;
        else if (ax >= ay) g = (dx >= 0) ? tcsr_pkg::G_SWIPE_RIGHT : tcsr_pkg::G_SWIPE_LEFT;
        else g = (dy >= 0) ? tcsr_pkg::G_SWIPE_DOWN : tcsr_pkg::G_SWIPE_UP;
      end
    end
    return g;
  endfunction

  // report driver: holds a stalled transfer, otherwise idles or sends the next report
  always @(negedge clk_i) begin : report_driver
    report_t r;
    if (rst_ni) begin
      if (in_valid_i && !report_taken) begin
        // stalled, payload stays
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_reports.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 9);
        in_valid_i <= 1'b0;
      end else if (pending_reports.size() != 0) begin
        r = pending_reports.pop_front();
        click_pressed_i  <= r.click;
        has_touch_data_i <= r.has_touch;
        touch_active_i   <= r.active;
        touch_x_i        <= r.x;
        touch_y_i        <= r.y;
        in_valid_i       <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
      report_taken = 1'b0;
    end
  end

  // input transfer: predict the gesture it causes
  always @(posedge clk_i) begin : report_accept
    report_t r;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      r.click     = click_pressed_i;
      r.has_touch = has_touch_data_i;
      r.active    = touch_active_i;
      r.x         = touch_x_i;
      r.y         = touch_y_i;
      gestures_due.push_back(next_gesture(r));
      report_taken = 1'b1;
    end
  end

  // random output backpressure in bursts
  always @(negedge clk_i) begin : gesture_backpressure
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(0, 9);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // gesture monitor: compare each output transfer with the oldest prediction
  always @(posedge clk_i) begin : gesture_monitor
    tcsr_pkg::gesture_e want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (gestures_due.size() == 0) begin
        report_mismatch($sformatf("gesture %0d with nothing outstanding", gesture_o));
      end else begin
        want = gestures_due.pop_front();
        if (gesture_o !== want)
          report_mismatch($sformatf("gesture %0d, wanted %0d (%s)",
                                    gesture_o, want, want.name()));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int clip(int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic void push_report(int c, int h, int a, int x, int y);
    report_t r;
    r.click     = 1'(c);
    r.has_touch = 1'(h);
    r.active    = 1'(a);
    r.x         = CB'(x);
    r.y         = CB'(y);
    pending_reports.push_back(r);
  endfunction

  // one touch from start point through a few moves to a lift, sometimes clicked midway
  function automatic void queue_swipe();
    int x0, y0, x1, y1, span, steps, click_from, click_len, lift;
    bit c;
    x0 = $urandom_range(0, COORD_MAX);
    y0 = $urandom_range(0, COORD_MAX);
    if ($urandom_range(0, 7) == 0) begin
      x1 = $urandom_range(0, COORD_MAX);
      y1 = $urandom_range(0, COORD_MAX);
    end else begin
      // end point scattered around the thresholds
      span = ((thr_x > thr_y) ? int'(thr_x) : int'(thr_y)) * 2 + 16;
      x1 = clip(x0 + int'($urandom_range(0, 2 * span)) - span);
      y1 = clip(y0 + int'($urandom_range(0, 2 * span)) - span);
    end
    steps = $urandom_range(0, 6);
    click_from = -1;
    click_len = 0;
    if ($urandom_range(0, 4) == 0) begin
      click_from = $urandom_range(0, steps);
      click_len = $urandom_range(1, 3);
    end
    for (int i = 0; i <= steps; i++) begin
      c = (click_from >= 0) && (i >= click_from) && (i < click_from + click_len);
      if (i == 0) push_report(int'(c), 1, 1, x0, y0);
      else push_report(int'(c), 1, 1, x0 + (x1 - x0) * i / steps,
                       y0 + (y1 - y0) * i / steps);
    end
    lift = $urandom_range(0, 2);
    push_report(0, int'(lift == 1), int'(lift == 0), $urandom_range(0, COORD_MAX),
                $urandom_range(0, COORD_MAX));
  endfunction

  // click press mostly near the region borders, held a little, then released
  function automatic void queue_click();
    int x, pick, holds;
    bit h;
    pick = $urandom_range(0, 4);
    case (pick)
      0: x = clip(int'(left_limit) - 1);
      1: x = int'(left_limit);
      2: x = clip(int'(right_start) - 1);
      3: x = int'(right_start);
      default: x = $urandom_range(0, COORD_MAX);
    endcase
    if ($urandom_range(0, 3) != 0) begin
      push_report(1, 1, 1, x, $urandom_range(0, COORD_MAX));
    end else begin
      h = 1'($urandom_range(0, 1));
      push_report(1, int'(h), h ? 0 : int'($urandom_range(0, 1)), x,
                  $urandom_range(0, COORD_MAX));
    end
    holds = $urandom_range(0, 2);
    for (int i = 0; i < holds; i++)
      push_report(1, $urandom_range(0, 1), $urandom_range(0, 1),
                  $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
    push_report(0, 0, $urandom_range(0, 1), $urandom_range(0, COORD_MAX),
                $urandom_range(0, COORD_MAX));
  endfunction

  // mostly whole swipes, some clicks and some raw noise
  function automatic void queue_mix(int n);
    int kind, noise;
    while (pending_reports.size() < n) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        queue_swipe();
      end else if (kind <= 7) begin
        queue_click();
      end else begin
        noise = $urandom_range(1, 3);
        for (int i = 0; i < noise; i++)
          push_report($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                      $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
      end
    end
  endfunction

  // wait until every report is sent and every gesture has come back
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_reports.size() != 0 || in_valid_i || gestures_due.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // write all four registers, called at a falling edge while idle
  task automatic load_settings(int tx, int ty, int ll, int rs);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= tcsr_pkg::CFG_THR_X;
    cfg_wdata_i <= CB'(tx);
    @(negedge clk_i);
    cfg_idx_i   <= tcsr_pkg::CFG_THR_Y;
    cfg_wdata_i <= CB'(ty);
    @(negedge clk_i);
    cfg_idx_i   <= tcsr_pkg::CFG_LEFT_LIMIT;
    cfg_wdata_i <= CB'(ll);
    @(negedge clk_i);
    cfg_idx_i   <= tcsr_pkg::CFG_RIGHT_START;
    cfg_wdata_i <= CB'(rs);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    thr_x       = CB'(tx);
    thr_y       = CB'(ty);
    left_limit  = CB'(ll);
    right_start = CB'(rs);
  endtask

  // stimulus
  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = tcsr_pkg::CFG_THR_X;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    click_pressed_i  = 1'b0;
    has_touch_data_i = 1'b0;
    touch_active_i   = 1'b0;
    touch_x_i        = '0;
    touch_y_i        = '0;
    out_stall_i      = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // click without touch data gives a mid press
    push_report(1, 0, 1, 100, 0);
    push_report(0, 0, 0, 0, 0);
    // region borders under the reset limits
    push_report(1, 1, 1, 0, 0);
    push_report(0, 0, 0, 0, 0);
    push_report(1, 1, 1, 639, COORD_MAX);
    push_report(0, 0, 0, 0, 0);
    push_report(1, 1, 1, 640, 0);
    push_report(0, 0, 0, 0, 0);
    push_report(1, 1, 1, 1279, 0);
    push_report(0, 0, 0, 0, 0);
    // swipe right, lifted by touch_active low
    push_report(0, 1, 1, 100, 100);
    push_report(0, 1, 1, 600, 150);
    push_report(0, 1, 0, 0, 0);
    // equal axes, horizontal wins
    push_report(0, 1, 1, 900, 900);
    push_report(0, 1, 1, 500, 500);
    push_report(0, 0, 1, COORD_MAX, COORD_MAX);
    // swipe down
    push_report(0, 1, 1, 300, 0);
    push_report(0, 1, 1, 400, 1000);
    push_report(0, 0, 0, 0, 0);
    // click during a track: right press, swipe suppressed, track keeps updating
    push_report(0, 1, 1, 200, 1800);
    push_report(1, 1, 1, COORD_MAX, 0);
    push_report(1, 1, 1, 1500, 200);
    push_report(0, 1, 1, 1800, 100);
    push_report(0, 0, 0, 0, 0);
    wait_idle();

    // random phases over several register settings
    queue_mix(240);
    wait_idle();
    load_settings(0, 0, 0, 0);
    queue_mix(235);
    wait_idle();
    load_settings(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    queue_mix(235);
    wait_idle();
    // crossed region limits
    load_settings(60, 900, 1500, 400);
    queue_mix(235);
    wait_idle();
    load_settings($urandom_range(0, 600), $urandom_range(0, 600),
                  $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
    queue_mix(235);
    wait_idle();
    // last stretch at full rate
    calm = 1'b1;
    load_settings($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                  $urandom_range(0, 1024), $urandom_range(1024, COORD_MAX));
    queue_mix(245);
    wait_idle();

    repeat (4) @(posedge clk_i);
    if (gestures_due.size() != 0)
      report_mismatch($sformatf("%0d gestures never arrived", gestures_due.size()));
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
